// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UVST_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define UVST_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/uvst_pkg.sv -----
package uvst_pkg;

  typedef logic [1:0] action_t;
  localparam action_t ACT_ADD    = 2'd0;
  localparam action_t ACT_REMOVE = 2'd1;
  localparam action_t ACT_LOOKUP = 2'd2;
  localparam action_t ACT_SPARE  = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t RES_ADDED   = 3'd0;
  localparam status_t RES_DUP     = 3'd1;
  localparam status_t RES_FULL    = 3'd2;
  localparam status_t RES_REMOVED = 3'd3;
  localparam status_t RES_ABSENT  = 3'd4;
  localparam status_t RES_FOUND   = 3'd5;

  localparam int POS_W = 6;
  localparam int CNT_W = 6;
  localparam logic [POS_W-1:0] POS_NONE = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic shift_init;
    logic shift;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    hit_now;
    logic    search_done;
    logic    shift_done;
    logic    out_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/unique_value_set_table.sv -----
// Channel  Dir  tdata                               tuser
// s_*      in   [63:0] value                        [1:0] action
// m_*      out  [5:0] position, [11:6] entry_count  [2:0] status
//
// One item at a time. Entries sit in a single-read-port memory that is
// scanned one entry per cycle until a match or the end of the table. A
// remove that hits then shifts the tail down to close the gap.
// Reset clears the count and all control state; entry contents need no clear.
// A held result does not block the next transfer in; only its reply waits.
module unique_value_set_table #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] position, [11:6] entry_count, [15:12] zero
  output logic [2:0]  m_tuser    // [2:0] status
);

  uvst_pkg::dp_cmd_t             cmd;
  uvst_pkg::dp_stat_t            stat;
  uvst_pkg::status_t             out_status;
  logic [uvst_pkg::POS_W-1:0]    out_position;
  logic [uvst_pkg::CNT_W-1:0]    out_count;

  uvst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  uvst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .action       (s_tuser),
    .value        (s_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .m_tready     (m_tready),
    .out_valid    (m_tvalid),
    .out_status   (out_status),
    .out_position (out_position),
    .out_count    (out_count)
  );

  assign m_tdata = {4'b0000, out_count, out_position};
  assign m_tuser = out_status;

endmodule

// ----- hw/rtl/uvst_ctrl.sv -----
module uvst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  uvst_pkg::dp_stat_t stat,
  output uvst_pkg::dp_cmd_t  cmd
);

  uvst_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uvst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      uvst_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = uvst_pkg::S_SEARCH;
        end
      end
      uvst_pkg::S_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.search_done) begin
          // A remove that hit closes the gap before replying.
          if (stat.action == uvst_pkg::ACT_REMOVE && stat.hit_now) begin
            cmd.shift_init = 1'b1;
            state_next     = uvst_pkg::S_SHIFT;
          end else begin
            state_next = uvst_pkg::S_REPLY;
          end
        end
      end
      uvst_pkg::S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_done) begin
          state_next = uvst_pkg::S_REPLY;
        end
      end
      uvst_pkg::S_REPLY: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = uvst_pkg::S_IDLE;
        end
      end
    endcase
  end

endmodule

// ----- hw/rtl/uvst_datapath.sv -----
module uvst_datapath #(
  parameter int CAPACITY = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  uvst_pkg::action_t              action,
  input  logic [63:0]                    value,
  input  uvst_pkg::dp_cmd_t              cmd,
  output uvst_pkg::dp_stat_t             stat,
  input  logic                           m_tready,
  output logic                           out_valid,
  output uvst_pkg::status_t              out_status,
  output logic [uvst_pkg::POS_W-1:0]     out_position,
  output logic [uvst_pkg::CNT_W-1:0]     out_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [63:0]       mem [CAPACITY];

  uvst_pkg::action_t action_q;
  logic [63:0]       value_q;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     ptr;
  logic              rd_pend;
  logic [AW-1:0]     rd_idx;
  logic [63:0]       mem_q;
  logic              hit_found;
  logic [AW-1:0]     hit_idx;

  logic              hit_now;
  logic              ptr_lt;
  logic              rd_en;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [63:0]       wr_data;
  logic              add_ok;
  uvst_pkg::status_t status_next;

  assign hit_now = rd_pend && (mem_q == value_q);
  assign ptr_lt  = ptr < count;
  assign rd_en   = (cmd.search && !hit_now && ptr_lt) || (cmd.shift && ptr_lt);

  assign stat.action      = action_q;
  assign stat.hit_now     = hit_now;
  assign stat.search_done = hit_now || (!rd_pend && !ptr_lt);
  assign stat.shift_done  = !rd_pend && !ptr_lt;
  assign stat.out_free    = !out_valid || m_tready;

  assign add_ok = (action_q == uvst_pkg::ACT_ADD) && !hit_found &&
                  (count != CW'(CAPACITY));

  always_comb begin
    count_next  = count;
    status_next = uvst_pkg::RES_ABSENT;
    unique case (action_q)
      uvst_pkg::ACT_ADD: begin
        if (hit_found) begin
          status_next = uvst_pkg::RES_DUP;
        end else if (!add_ok) begin
          status_next = uvst_pkg::RES_FULL;
        end else begin
          status_next = uvst_pkg::RES_ADDED;
          count_next  = count + CW'(1);
        end
      end
      uvst_pkg::ACT_REMOVE: begin
        if (hit_found) begin
          status_next = uvst_pkg::RES_REMOVED;
          count_next  = count - CW'(1);
        end
      end
      default: begin
        // Lookup, and the unused code that behaves as one.
        status_next = hit_found ? uvst_pkg::RES_FOUND : uvst_pkg::RES_ABSENT;
      end
    endcase
  end

  // One write port: shifting entries down, or appending on a successful add.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = value_q;
    if (cmd.shift && rd_pend) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx - AW'(1);
      wr_data = mem_q;
    end else if (cmd.finish && add_ok) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ptr       <= '0;
      rd_pend   <= 1'b0;
      hit_found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr       <= '0;
        rd_pend   <= 1'b0;
        hit_found <= 1'b0;
      end else if (cmd.shift_init) begin
        ptr     <= CW'(rd_idx) + CW'(1);
        rd_pend <= 1'b0;
      end else if (cmd.search || cmd.shift) begin
        if (rd_en) begin
          ptr <= ptr + CW'(1);
        end
        rd_pend <= rd_en;
      end
      if (cmd.search && hit_now) begin
        hit_found <= 1'b1;
      end
      if (cmd.finish) begin
        count <= count_next;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= action;
      value_q  <= value;
    end
    if (rd_en) begin
      rd_idx <= ptr[AW-1:0];
      mem_q  <= mem[ptr[AW-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.search && hit_now) begin
      hit_idx <= rd_idx;
    end
    if (cmd.finish) begin
      out_status   <= status_next;
      out_position <= hit_found ? uvst_pkg::POS_W'(hit_idx) : uvst_pkg::POS_NONE;
      out_count    <= uvst_pkg::CNT_W'(count_next);
    end
  end

endmodule

// ----- hw/rtl/uvst_checker.sv -----
`include "assert_macros.svh"

module uvst_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // A stalled result keeps its content.
  `UVST_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // Outcomes with no matching entry always carry the no-match position.
  `UVST_ASSERT_IMP(a_nomatch_pos, clk, rst, m_tvalid && (m_tuser == uvst_pkg::RES_ADDED || m_tuser == uvst_pkg::RES_FULL || m_tuser == uvst_pkg::RES_ABSENT), m_tdata[5:0] == uvst_pkg::POS_NONE)

  // A result never appears in the cycle right after its transfer in.
  `UVST_ASSERT_NEXT(a_no_early, clk, rst, s_tvalid && s_tready, !$rose(m_tvalid))

  // Coming out of reset, no result is offered.
  `UVST_ASSERT_IMP(a_reset_idle, clk, rst, $past(rst), !m_tvalid)

endmodule

bind unique_value_set_table uvst_checker u_uvst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
